FILE: sv/wmsm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the window mean / deviation motion detector.
package wmsm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int STD_W       = 21;
    localparam int THR_W       = 16;
    localparam int VAR_SCALE_W = 8;   // 256 * V gives sixteen times the root
    localparam logic [THR_W-1:0] THR_RESET = 16'd10;

    typedef struct packed {
        logic                sample_ready;
        logic [SAMPLE_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean_value;
        logic [STD_W-1:0]    std_dev_x16;
        logic                motion_detected;
    } t_out_item;

    typedef enum logic [1:0] {
        WIN_HOLD,
        WIN_LOAD,
        WIN_ROTATE
    } t_win_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MEAN,
        ST_VAR,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DONE
    } t_state;

endpackage

FILE: sv/wmsm_window.sv
`timescale 1ns / 1ps
// Sample window: shift line that loads a new sample or rotates in place.
module wmsm_window #(
    parameter int DEPTH = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wmsm_pkg::t_win_op                  i_op,
    input  wmsm_pkg::t_in_item                 i_item,
    output logic [wmsm_pkg::SAMPLE_W-1:0]      o_head
);

    logic [wmsm_pkg::SAMPLE_W-1:0] r_win [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            unique case (i_op)
                wmsm_pkg::WIN_LOAD: begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        r_win[i] <= r_win[i+1];
                    end
                    // top slot keeps its old value when no fresh sample
                    if (i_item.sample_ready) begin
                        r_win[DEPTH-1] <= i_item.sample_value;
                    end
                end
                wmsm_pkg::WIN_ROTATE: begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        r_win[i] <= r_win[i+1];
                    end
                    r_win[DEPTH-1] <= r_win[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_head = r_win[0];

endmodule

FILE: sv/wmsm_unit.sv
`timescale 1ns / 1ps
// Compare-subtract unit: largest root r with SCALE * r * r <= value, one bit a cycle.
module wmsm_unit #(
    parameter int UW    = 44,
    parameter int RW    = 21,
    parameter int SCALE = 8,
    localparam int TW    = ((UW > 2 * RW) ? UW : 2 * RW) + $clog2(SCALE + 1) + 1,
    localparam int CNT_W = $clog2(RW + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [UW-1:0]         i_value,
    output logic                  o_busy,
    output logic [RW-1:0]         o_result
);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [TW-1:0]        r_rem;   // value left after the accepted trials
    logic [TW-1:0]        r_t1;    // SCALE * root so far, aligned to the trial bit
    logic [TW-1:0]        r_t2;    // SCALE * trial bit squared
    logic [RW-1:0]        r_root;

    logic [TW-1:0]        w_trial;
    logic [TW:0]          w_diff;
    logic                 w_ge;

    assign w_trial = r_t1 + r_t2;
    assign w_diff  = {1'b0, r_rem} - {1'b0, w_trial};
    assign w_ge    = !w_diff[TW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(RW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= TW'(i_value);
            r_t1   <= '0;
            r_t2   <= TW'(SCALE) << (2 * (RW - 1));
            r_root <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_diff[TW-1:0];
            end
            r_t1   <= w_ge ? ((r_t1 >> 1) + r_t2) : (r_t1 >> 1);
            r_t2   <= r_t2 >> 2;
            r_root <= {r_root[RW-2:0], w_ge};
        end
    end

    assign o_busy   = r_busy;
    assign o_result = r_root;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("unit started while busy");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("unit busy with zero step count");

    a_trial_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_t2 != '0))
        else $error("root trial term lost");

endmodule

FILE: sv/window_mean_stdev_motion.sv
`timescale 1ns / 1ps
// Top level: sequencer, accumulators and result register of the motion detector.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready   i_in  (t_in_item)
//   out       output     o_out_valid / i_out_ready o_out (t_out_item)
//   cfg       input      i_cfg_we                  i_cfg_wdata (motion threshold)
//
// From accept to the next ready, one transaction runs these steps in order, with the
// input not ready: summing the rotating window, one reciprocal multiply for the mean,
// the squared deviations, start and wait on the compare-subtract root unit, loading
// the result, then ready again.
// Synchronous active-low reset clears the window to zero and the threshold to 10.
// A stalled output holds the next result in the final state, and the input stays off.
module window_mean_stdev_motion #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  wmsm_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output wmsm_pkg::t_out_item               o_out,
    input  logic                              i_cfg_we,
    input  logic [wmsm_pkg::THR_W-1:0]        i_cfg_wdata
);

    localparam int SW       = wmsm_pkg::SAMPLE_W;
    localparam int SUM_W    = SW + $clog2(WINDOW_DEPTH);
    localparam int VAR_W    = 2 * SW + $clog2(WINDOW_DEPTH);
    localparam int UW       = VAR_W + wmsm_pkg::VAR_SCALE_W;
    localparam int CW       = $clog2(WINDOW_DEPTH + 1);
    localparam int SQ_W     = 2 * SW;
    // exact floor division of the sum by D-1 through a rounded-up reciprocal
    localparam int MEAN_DIV = WINDOW_DEPTH - 1;
    localparam int REC_S    = SUM_W + $clog2(MEAN_DIV);
    localparam longint REC_M = ((longint'(1) << REC_S) + longint'(MEAN_DIV - 1))
                               / longint'(MEAN_DIV);
    localparam int REC_W    = SUM_W + 1;
    localparam int PROD_W   = SUM_W + REC_W;

    wmsm_pkg::t_state     r_state, n_state;
    logic [CW-1:0]        r_cnt;
    logic [SUM_W-1:0]     r_sum;
    logic [SW-1:0]        r_mean;
    logic [SW-1:0]        r_d;
    logic                 r_d_v;
    logic [SQ_W-1:0]      r_sq;
    logic                 r_sq_v;
    logic [VAR_W-1:0]     r_var;
    logic [SQ_W-1:0]      r_thr2;
    logic [VAR_W-1:0]     r_limit;
    logic                 r_motion;
    logic [wmsm_pkg::THR_W-1:0] r_thr;
    logic                 r_out_valid;
    wmsm_pkg::t_out_item  r_out;

    wmsm_pkg::t_win_op    w_win_op;
    logic                 w_unit_start;
    logic [UW-1:0]        w_unit_value;
    logic                 w_unit_busy;
    logic [wmsm_pkg::STD_W-1:0] w_unit_res;
    logic [SW-1:0]        w_head;
    logic                 w_in_acc;
    logic                 w_out_load;
    logic [VAR_W-1:0]     w_limit;
    logic [PROD_W-1:0]    w_mean_prod;

    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_out_load   = (r_state == wmsm_pkg::ST_DONE) && (!r_out_valid || i_out_ready);
    assign w_limit      = VAR_W'(r_thr2) * VAR_W'(WINDOW_DEPTH - 2);
    assign w_mean_prod  = PROD_W'(r_sum) * PROD_W'(REC_M);
    assign w_unit_value = {r_var, {wmsm_pkg::VAR_SCALE_W{1'b0}}};

    wmsm_window #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_win_op),
        .i_item  (i_in),
        .o_head  (w_head)
    );

    // root of 256 * V / (D - 2), found as the largest r with (D - 2) * r * r <= 256 * V
    wmsm_unit #(
        .UW    (UW),
        .RW    (wmsm_pkg::STD_W),
        .SCALE (WINDOW_DEPTH - 2)
    ) u_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_unit_start),
        .i_value   (w_unit_value),
        .o_busy    (w_unit_busy),
        .o_result  (w_unit_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmsm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        w_win_op     = wmsm_pkg::WIN_HOLD;
        w_unit_start = 1'b0;
        unique case (r_state)
            wmsm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_win_op = wmsm_pkg::WIN_LOAD;
                    n_state  = wmsm_pkg::ST_SUM;
                end
            end
            wmsm_pkg::ST_SUM: begin
                w_win_op = wmsm_pkg::WIN_ROTATE;
                if (r_cnt == CW'(WINDOW_DEPTH - 1)) begin
                    n_state = wmsm_pkg::ST_MEAN;
                end
            end
            wmsm_pkg::ST_MEAN: begin
                n_state = wmsm_pkg::ST_VAR;
            end
            wmsm_pkg::ST_VAR: begin
                if (r_cnt < CW'(WINDOW_DEPTH)) begin
                    w_win_op = wmsm_pkg::WIN_ROTATE;
                end else begin
                    n_state = wmsm_pkg::ST_SQRT_GO;
                end
            end
            wmsm_pkg::ST_SQRT_GO: begin
                w_unit_start = 1'b1;
                n_state      = wmsm_pkg::ST_SQRT_WAIT;
            end
            wmsm_pkg::ST_SQRT_WAIT: begin
                if (!w_unit_busy) begin
                    n_state = wmsm_pkg::ST_DONE;
                end
            end
            wmsm_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = wmsm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wmsm_pkg::ST_IDLE;
            end
        endcase
    end

    // control counters and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_d_v       <= 1'b0;
            r_sq_v      <= 1'b0;
            r_thr       <= wmsm_pkg::THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc || r_state == wmsm_pkg::ST_MEAN) begin
                r_cnt  <= '0;
                r_d_v  <= 1'b0;
                r_sq_v <= 1'b0;
            end else if (r_state == wmsm_pkg::ST_SUM || r_state == wmsm_pkg::ST_VAR) begin
                r_cnt  <= r_cnt + CW'(1);
                r_d_v  <= (r_state == wmsm_pkg::ST_VAR) && (r_cnt < CW'(WINDOW_DEPTH - 1));
                r_sq_v <= r_d_v;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sum <= '0;
        end else if (r_state == wmsm_pkg::ST_SUM && r_cnt < CW'(WINDOW_DEPTH - 1)) begin
            r_sum <= r_sum + SUM_W'(w_head);
        end
        if (r_state == wmsm_pkg::ST_MEAN) begin
            r_mean <= w_mean_prod[REC_S +: SW];
            r_var  <= '0;
            r_thr2 <= SQ_W'(r_thr) * SQ_W'(r_thr);
        end
        if (r_state == wmsm_pkg::ST_VAR) begin
            r_d     <= (r_mean > w_head) ? (r_mean - w_head) : (w_head - r_mean);
            r_sq    <= SQ_W'(r_d) * SQ_W'(r_d);
            r_limit <= w_limit;
            if (r_sq_v) begin
                r_var <= r_var + VAR_W'(r_sq);
            end
        end
        if (r_state == wmsm_pkg::ST_SQRT_GO) begin
            r_motion <= (r_var > r_limit);
        end
        if (w_out_load) begin
            r_out.mean_value      <= r_mean;
            r_out.std_dev_x16     <= w_unit_res;
            r_out.motion_detected <= r_motion;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_ready_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_unit_busy)
        else $error("input ready while unit still busy");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wmsm_pkg::ST_DONE && r_out_valid && !i_out_ready)
        |=> (r_state == wmsm_pkg::ST_DONE && r_out_valid))
        else $error("result dropped while output stalled");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == wmsm_pkg::ST_SUM && r_cnt == '0))
        else $error("accepted transaction did not start the sum pass");

endmodule

FILE: sim/window_mean_stdev_motion_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window mean / deviation motion detector.
module window_mean_stdev_motion_tb;

    localparam int DEPTH       = 10;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 230;
    localparam int DRAIN       = 150;   // well over one transaction's latency
    localparam int LONG_HOLD   = 600;
    localparam int STUCK_LIMIT = 4000;

    typedef struct packed {
        wmsm_pkg::t_in_item  item;
        logic                has_lit;
        wmsm_pkg::t_out_item lit;
    } t_dir_row;

    localparam int DIR_N = 20;
    // Literal rows: zero window after reset, newest slot excluded from stats,
    // and a window full of one value (deviation zero).
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{'{1'b0, 16'hFFFF}, 1'b1, '{16'd0,     21'd0, 1'b0}},
        '{'{1'b1, 16'hFFFF}, 1'b1, '{16'd0,     21'd0, 1'b0}},
        '{'{1'b1, 16'hFFFF}, 1'b0, '0},
        '{'{1'b1, 16'hFFFF}, 1'b0, '0},
        '{'{1'b1, 16'hFFFF}, 1'b0, '0},
        '{'{1'b1, 16'hFFFF}, 1'b0, '0},
        '{'{1'b1, 16'hFFFF}, 1'b0, '0},
        '{'{1'b1, 16'hFFFF}, 1'b0, '0},
        '{'{1'b1, 16'hFFFF}, 1'b0, '0},
        '{'{1'b1, 16'hFFFF}, 1'b0, '0},
        '{'{1'b1, 16'hFFFF}, 1'b1, '{16'hFFFF,  21'd0, 1'b0}},
        '{'{1'b1, 16'h0000}, 1'b1, '{16'hFFFF,  21'd0, 1'b0}},
        '{'{1'b0, 16'h1234}, 1'b0, '0},
        '{'{1'b0, 16'hFFFF}, 1'b0, '0},
        '{'{1'b1, 16'h5555}, 1'b0, '0},
        '{'{1'b1, 16'hAAAA}, 1'b0, '0},
        '{'{1'b1, 16'h0001}, 1'b0, '0},
        '{'{1'b1, 16'h8000}, 1'b0, '0},
        '{'{1'b0, 16'h7FFF}, 1'b0, '0},
        '{'{1'b1, 16'h0000}, 1'b0, '0}
    };

    logic                       i_clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    wmsm_pkg::t_in_item         in_data = '0;
    logic                       out_ready = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [wmsm_pkg::THR_W-1:0] cfg_wdata = '0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    wmsm_pkg::t_out_item        o_out;

    // side channel carried with the payload: literal expectation, if any
    logic                lit_on = 1'b0;
    wmsm_pkg::t_out_item lit_val = '0;

    logic [wmsm_pkg::SAMPLE_W-1:0] window_model [DEPTH];
    logic [wmsm_pkg::THR_W-1:0]    thr_model = wmsm_pkg::THR_RESET;
    wmsm_pkg::t_out_item           pending_stats [$];
    wmsm_pkg::t_out_item           predicted, wanted;
    int                            mismatch_cnt = 0;
    int                            stuck_cycles = 0;
    bit                            stall_en = 1'b1;
    bit                            hold_req = 1'b0;

    // random-stimulus shaping
    int                            burst_style;
    int                            spread;
    logic [wmsm_pkg::SAMPLE_W-1:0] base_val;
    logic [wmsm_pkg::THR_W-1:0]    thr_pick;

    window_mean_stdev_motion #(.WINDOW_DEPTH(DEPTH)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        for (int k = 0; k < DEPTH; k++) window_model[k] = '0;
    end

    function automatic logic [wmsm_pkg::STD_W-1:0] floor_root(input longint unsigned v);
        logic [wmsm_pkg::STD_W-1:0] root;
        longint unsigned            cand;
        root = '0;
        for (int b = wmsm_pkg::STD_W - 1; b >= 0; b--) begin
            cand = longint'(root) | (64'd1 << b);
            if (cand * cand <= v) root[b] = 1'b1;
        end
        return root;
    endfunction

    // shift the window, then mean / deviation / motion over the oldest DEPTH-1 slots
    function automatic wmsm_pkg::t_out_item advance_window(input wmsm_pkg::t_in_item it);
        longint unsigned     total, avg, dev, sq_sum, scaled, limit;
        wmsm_pkg::t_out_item r;
        for (int k = 0; k < DEPTH - 1; k++) window_model[k] = window_model[k + 1];
        if (it.sample_ready) window_model[DEPTH - 1] = it.sample_value;
        total = 0;
        for (int k = 0; k < DEPTH - 1; k++) total += window_model[k];
        avg = total / (DEPTH - 1);
        sq_sum = 0;
        for (int k = 0; k < DEPTH - 1; k++) begin
            dev = (avg > window_model[k]) ? avg - window_model[k] : window_model[k] - avg;
            sq_sum += dev * dev;
        end
        scaled = (sq_sum << wmsm_pkg::VAR_SCALE_W) / (DEPTH - 2);
        limit  = longint'(thr_model) * longint'(thr_model) * (DEPTH - 2);
        r.mean_value      = avg[wmsm_pkg::SAMPLE_W-1:0];
        r.std_dev_x16     = floor_root(scaled);
        r.motion_detected = (sq_sum > limit);
        return r;
    endfunction

    function automatic wmsm_pkg::t_in_item next_sample();
        wmsm_pkg::t_in_item it;
        int                 v;
        case (burst_style)
            0: begin
                v = int'(base_val) + int'($urandom_range(0, 2 * spread)) - spread;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                it.sample_value = v[wmsm_pkg::SAMPLE_W-1:0];
                it.sample_ready = ($urandom_range(0, 9) != 0);
            end
            1: begin
                it.sample_value = wmsm_pkg::SAMPLE_W'($urandom_range(0, 65535));
                it.sample_ready = ($urandom_range(0, 9) < 7);
            end
            default: begin
                it.sample_value = base_val;
                it.sample_ready = ($urandom_range(0, 9) != 0);
            end
        endcase
        return it;
    endfunction

    // transaction monitor and scoreboard
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (in_valid && o_in_ready) begin
                predicted = advance_window(in_data);
                pending_stats.push_back(lit_on ? lit_val : predicted);
            end
            if (o_out_valid && out_ready) begin
                if (pending_stats.size() == 0) begin
                    $error("unexpected result: mean %0d std %0d motion %0d",
                           o_out.mean_value, o_out.std_dev_x16, o_out.motion_detected);
                    mismatch_cnt++;
                end else begin
                    wanted = pending_stats.pop_front();
                    if (o_out.mean_value !== wanted.mean_value) begin
                        $error("mean_value: expected %0d, got %0d",
                               wanted.mean_value, o_out.mean_value);
                        mismatch_cnt++;
                    end
                    if (o_out.std_dev_x16 !== wanted.std_dev_x16) begin
                        $error("std_dev_x16: expected %0d, got %0d",
                               wanted.std_dev_x16, o_out.std_dev_x16);
                        mismatch_cnt++;
                    end
                    if (o_out.motion_detected !== wanted.motion_detected) begin
                        $error("motion_detected: expected %0d, got %0d",
                               wanted.motion_detected, o_out.motion_detected);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) stuck_cycles <= 0;
        else stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    // result side: random stalls, plus one long hold so the block backs up
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end else if (stall_en && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input wmsm_pkg::t_in_item it, input logic has_lit,
                             input wmsm_pkg::t_out_item lit);
        if (stall_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        lit_on   <= has_lit;
        lit_val  <= lit;
        do @(posedge i_clk); while (!(in_valid && o_in_ready));
    endtask

    task automatic wait_drained();
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic load_threshold(input logic [wmsm_pkg::THR_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        thr_model = v;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_N; r++)
            send_item(DIR_ROWS[r].item, DIR_ROWS[r].has_lit, DIR_ROWS[r].lit);
        in_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: thr_pick = '0;
                1: thr_pick = '1;
                2: thr_pick = 16'd1;
                3: thr_pick = wmsm_pkg::THR_W'($urandom_range(0, 64));
                4: thr_pick = wmsm_pkg::THR_W'($urandom_range(0, 4000));
                5: thr_pick = wmsm_pkg::THR_W'($urandom_range(0, 65535));
                6: thr_pick = wmsm_pkg::THR_W'($urandom_range(100, 20000));
                default: thr_pick = wmsm_pkg::THR_W'($urandom_range(0, 2000));
            endcase
            load_threshold(thr_pick);
            hold_req = (ph == 2);
            stall_en = (ph != PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 24 == 0) begin
                    // new burst: noisy plateau, full-range noise or a flat level
                    burst_style = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);
                    base_val    = wmsm_pkg::SAMPLE_W'($urandom_range(0, 65535));
                    spread      = 1 << $urandom_range(0, 15);
                end
                send_item(next_sample(), 1'b0, '0);
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/wmsm_pkg.sv
sv/wmsm_window.sv
sv/wmsm_unit.sv
sv/window_mean_stdev_motion.sv
sim/window_mean_stdev_motion_tb.sv
